/* src/fskwd_pkg.sv */
// Shared types, constants and register codes for the FSK window demodulator.
package fskwd_pkg;

  // WINDOW_MAX must be a power of two: head and address math wrap by truncation.
  localparam int unsigned WINDOW_MAX  = 256;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned WIN_AW = $clog2(WINDOW_MAX);
  localparam int unsigned FILL_W = WIN_AW + 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + WIN_AW;

  localparam int unsigned S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_ZERO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_ONE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMPLITUDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISMATCH    = 3'd4;

  localparam logic [8:0]  RST_WINDOW_LENGTH   = 9'd48;
  localparam logic [31:0] RST_PHASE_STEP_ZERO = 32'd178956971;
  localparam logic [31:0] RST_PHASE_STEP_ONE  = 32'd357913941;
  localparam logic [14:0] RST_MIN_AMPLITUDE   = 15'd3277;
  localparam logic [16:0] RST_MAX_MISMATCH    = 17'd16384;

  // pi/2 in Q1.14, rounded
  localparam logic [14:0] HALF_PI_Q14 = 15'd25736;

  // amplitude compare alignment to a 16-bit sample scale
  localparam int unsigned AMP_SHL_R = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int unsigned AMP_SHL_L = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int unsigned AMP_LPROD_W = SUM_W + 15;
  localparam int unsigned AMP_RPROD_W = 15 + FILL_W;
  localparam int unsigned AMP_LHS_W = AMP_LPROD_W + AMP_SHL_L;
  localparam int unsigned AMP_RHS_W = AMP_RPROD_W + 14 + AMP_SHL_R;
  localparam int unsigned AMP_W = (AMP_LHS_W > AMP_RHS_W) ? AMP_LHS_W : AMP_RHS_W;
  localparam int unsigned ERR_W = FILL_W + 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_LAST,
    ST_MUL,
    ST_CMP
  } fskwd_state_e;

  typedef struct packed {
    logic push;
    logic clear;
    logic rd_en;
  } win_ctrl_t;

endpackage

/* src/fskwd_window.sv */
// Sliding sample window: circular store plus head and fill tracking.
module fskwd_window (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fskwd_pkg::win_ctrl_t                   ctrl_i,
  input  logic signed [fskwd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [fskwd_pkg::FILL_W-1:0]           len_i,
  input  logic [fskwd_pkg::FILL_W-1:0]           rd_idx_i,
  output logic                                   full_o,
  output logic signed [fskwd_pkg::SAMPLE_BITS-1:0] rd_data_o
);

  logic signed [fskwd_pkg::SAMPLE_BITS-1:0] mem [fskwd_pkg::WINDOW_MAX];

  logic [fskwd_pkg::WIN_AW-1:0] head_q, head_d;
  logic [fskwd_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [fskwd_pkg::WIN_AW-1:0] head_a;
  logic [fskwd_pkg::FILL_W-1:0] fill_a, fill_b, fill_over;
  logic [fskwd_pkg::WIN_AW-1:0] wr_addr, rd_addr;

  always_comb begin
    head_a = head_q;
    fill_a = fill_q;
    // store completely full: drop the oldest entry first
    if (fill_q[fskwd_pkg::WIN_AW]) begin
      head_a = head_q + 1'b1;
      fill_a = fskwd_pkg::FILL_W'(fskwd_pkg::WINDOW_MAX - 1);
    end
    wr_addr   = head_a + fill_a[fskwd_pkg::WIN_AW-1:0];
    fill_b    = fill_a + 1'b1;
    fill_over = fill_b - len_i;
    head_d    = head_q;
    fill_d    = fill_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      fill_d = '0;
    end else if (ctrl_i.push) begin
      if (fill_b > len_i) begin
        // window shortened or sliding: drop surplus oldest samples
        head_d = head_a + fill_over[fskwd_pkg::WIN_AW-1:0];
        fill_d = len_i;
      end else begin
        head_d = head_a;
        fill_d = fill_b;
      end
    end
  end

  assign rd_addr = head_q + rd_idx_i[fskwd_pkg::WIN_AW-1:0];
  assign full_o  = (fill_q == len_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_addr] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_o <= mem[rd_addr];
    end
  end

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (fill_q == '0 && head_q == '0))
    else $error("window not empty after clear");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && !ctrl_i.clear) |=> (fill_q != '0 && fill_q <= $past(len_i)))
    else $error("fill out of range after push");

endmodule

/* src/fskwd_accum.sv */
// Shared per-sample unit: reference phases, mismatch counts, absolute sum.
module fskwd_accum (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     clr_i,
  input  logic                                     en_i,
  input  logic signed [fskwd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [31:0]                              step0_i,
  input  logic [31:0]                              step1_i,
  output logic [fskwd_pkg::SUM_W-1:0]              sum_abs_o,
  output logic [fskwd_pkg::FILL_W-1:0]             miss0_o,
  output logic [fskwd_pkg::FILL_W-1:0]             miss1_o
);

  logic [31:0] ph0_q, ph1_q;
  logic [fskwd_pkg::SUM_W-1:0]  sum_q;
  logic [fskwd_pkg::FILL_W-1:0] miss0_q, miss1_q;
  logic                         s_zero, s_pos, mis0, mis1;
  logic signed [fskwd_pkg::SAMPLE_BITS:0] s_ext;
  logic [fskwd_pkg::SAMPLE_BITS-1:0]      s_abs;

  function automatic logic ref_miss(input logic [31:0] ph, input logic zero, input logic pos);
    logic ref_pos;
    ref_pos = !ph[31];
    if (ph[30:0] == '0 || zero) begin
      return 1'b1;
    end
    return ref_pos != pos;
  endfunction

  always_comb begin
    s_zero = (sample_i == '0);
    s_pos  = !sample_i[fskwd_pkg::SAMPLE_BITS-1] && !s_zero;
    s_ext  = {sample_i[fskwd_pkg::SAMPLE_BITS-1], sample_i};
    s_abs  = sample_i[fskwd_pkg::SAMPLE_BITS-1] ?
             fskwd_pkg::SAMPLE_BITS'(-s_ext) : fskwd_pkg::SAMPLE_BITS'(s_ext);
    mis0   = ref_miss(ph0_q, s_zero, s_pos);
    mis1   = ref_miss(ph1_q, s_zero, s_pos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph0_q   <= '0;
      ph1_q   <= '0;
      sum_q   <= '0;
      miss0_q <= '0;
      miss1_q <= '0;
    end else if (clr_i) begin
      ph0_q   <= '0;
      ph1_q   <= '0;
      sum_q   <= '0;
      miss0_q <= '0;
      miss1_q <= '0;
    end else if (en_i) begin
      ph0_q   <= ph0_q + step0_i;
      ph1_q   <= ph1_q + step1_i;
      sum_q   <= sum_q + fskwd_pkg::SUM_W'(s_abs);
      miss0_q <= miss0_q + fskwd_pkg::FILL_W'(mis0);
      miss1_q <= miss1_q + fskwd_pkg::FILL_W'(mis1);
    end
  end

  assign sum_abs_o = sum_q;
  assign miss0_o   = miss0_q;
  assign miss1_o   = miss1_q;

endmodule

/* src/fsk_window_demodulator.sv */
// Top level: sequencer, decision logic, bit packing and stream ports.
// Sequence: a sample that does not complete the window is accepted, then checked.
// A sample that completes the window passes through accept, check, one read beat
//   per window sample through the single window port, last beat, multiply and
//   compare; compare may wait for the output register. No sample is taken meanwhile.
// Reset: asynchronous, active low; configuration and state registers return to
//   their defaults, the window empties. Window memory is not cleared (no clearing pass).
module fsk_window_demodulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // s_axis_tdata: sample [SAMPLE_BITS-1:0], zero padded
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fskwd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // m_axis_tdata: data_byte [7:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fskwd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [fskwd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fskwd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  fskwd_pkg::fskwd_state_e st_q, st_d;
  fskwd_pkg::win_ctrl_t    win_ctrl;

  logic [8:0]  wl_q;
  logic [31:0] step0_q, step1_q;
  logic [14:0] min_amp_q;
  logic [16:0] max_mis_q;

  logic [fskwd_pkg::FILL_W-1:0] len_eff;
  logic [fskwd_pkg::FILL_W-1:0] idx_q, idx_d;
  logic                         rd_vld_q;
  logic                         win_full;
  logic signed [fskwd_pkg::SAMPLE_BITS-1:0] rd_data;
  logic signed [fskwd_pkg::SAMPLE_BITS-1:0] in_sample;

  logic                         acc_clr;
  logic [fskwd_pkg::SUM_W-1:0]  sum_abs;
  logic [fskwd_pkg::FILL_W-1:0] miss0, miss1, best;

  logic [fskwd_pkg::AMP_LPROD_W-1:0] amp_lprod;
  logic [fskwd_pkg::AMP_RPROD_W-1:0] amp_rprod;
  logic [fskwd_pkg::ERR_W-1:0]       err_rprod;
  logic [fskwd_pkg::AMP_W-1:0]       amp_l_q, amp_r_q;
  logic [fskwd_pkg::ERR_W-1:0]       err_l_q, err_r_q;
  logic                              bit_q;
  logic                              keep;

  logic [7:0] acc_q, acc_d;
  logic [2:0] bits_q, bits_d;
  logic [7:0] byte_q;
  logic       m_vld_q;
  logic       out_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q      <= fskwd_pkg::RST_WINDOW_LENGTH;
      step0_q   <= fskwd_pkg::RST_PHASE_STEP_ZERO;
      step1_q   <= fskwd_pkg::RST_PHASE_STEP_ONE;
      min_amp_q <= fskwd_pkg::RST_MIN_AMPLITUDE;
      max_mis_q <= fskwd_pkg::RST_MAX_MISMATCH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fskwd_pkg::CFG_WINDOW_LENGTH:   wl_q      <= cfg_data_i[8:0];
        fskwd_pkg::CFG_PHASE_STEP_ZERO: step0_q   <= cfg_data_i;
        fskwd_pkg::CFG_PHASE_STEP_ONE:  step1_q   <= cfg_data_i;
        fskwd_pkg::CFG_MIN_AMPLITUDE:   min_amp_q <= cfg_data_i[14:0];
        fskwd_pkg::CFG_MAX_MISMATCH:    max_mis_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wl_q == '0) begin
      len_eff = fskwd_pkg::FILL_W'(1);
    end else if (32'(wl_q) > fskwd_pkg::WINDOW_MAX) begin
      len_eff = fskwd_pkg::FILL_W'(fskwd_pkg::WINDOW_MAX);
    end else begin
      len_eff = fskwd_pkg::FILL_W'(wl_q);
    end
  end

  assign in_sample = s_axis_tdata[fskwd_pkg::SAMPLE_BITS-1:0];

  fskwd_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .sample_i  (in_sample),
    .len_i     (len_eff),
    .rd_idx_i  (idx_q),
    .full_o    (win_full),
    .rd_data_o (rd_data)
  );

  fskwd_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (acc_clr),
    .en_i      (rd_vld_q),
    .sample_i  (rd_data),
    .step0_i   (step0_q),
    .step1_i   (step1_q),
    .sum_abs_o (sum_abs),
    .miss0_o   (miss0),
    .miss1_o   (miss1)
  );

  // decision products
  assign best      = (miss0 < miss1) ? miss0 : miss1;
  assign amp_lprod = fskwd_pkg::AMP_LPROD_W'(sum_abs) *
                     fskwd_pkg::AMP_LPROD_W'(fskwd_pkg::HALF_PI_Q14);
  assign amp_rprod = fskwd_pkg::AMP_RPROD_W'(min_amp_q) * fskwd_pkg::AMP_RPROD_W'(len_eff);
  assign err_rprod = fskwd_pkg::ERR_W'(max_mis_q) * fskwd_pkg::ERR_W'(len_eff);

  always_ff @(posedge clk_i) begin
    if (st_q == fskwd_pkg::ST_MUL) begin
      amp_l_q <= fskwd_pkg::AMP_W'(amp_lprod) << fskwd_pkg::AMP_SHL_L;
      amp_r_q <= fskwd_pkg::AMP_W'(amp_rprod) << (14 + fskwd_pkg::AMP_SHL_R);
      err_l_q <= fskwd_pkg::ERR_W'(best) << 16;
      err_r_q <= err_rprod;
      bit_q   <= (miss1 < miss0);
    end
  end

  assign keep = !(amp_l_q < amp_r_q) && !(err_l_q > err_r_q);

  // sequencer
  always_comb begin
    st_d           = st_q;
    idx_d          = idx_q;
    win_ctrl       = '0;
    acc_clr        = 1'b0;
    acc_d          = acc_q;
    bits_d         = bits_q;
    out_load       = 1'b0;
    s_axis_tready  = 1'b0;
    case (st_q)
      fskwd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          win_ctrl.push = 1'b1;
          st_d          = fskwd_pkg::ST_CHK;
        end
      end
      fskwd_pkg::ST_CHK: begin
        if (win_full) begin
          acc_clr = 1'b1;
          idx_d   = '0;
          st_d    = fskwd_pkg::ST_SCAN;
        end else begin
          st_d = fskwd_pkg::ST_IDLE;
        end
      end
      fskwd_pkg::ST_SCAN: begin
        win_ctrl.rd_en = 1'b1;
        idx_d          = idx_q + 1'b1;
        if (idx_q == len_eff - 1'b1) begin
          st_d = fskwd_pkg::ST_LAST;
        end
      end
      fskwd_pkg::ST_LAST: begin
        st_d = fskwd_pkg::ST_MUL;
      end
      fskwd_pkg::ST_MUL: begin
        st_d = fskwd_pkg::ST_CMP;
      end
      fskwd_pkg::ST_CMP: begin
        if (!keep) begin
          st_d = fskwd_pkg::ST_IDLE;
        end else if (bits_q == 3'd7) begin
          // full byte: wait for the output register to free up
          if (!m_vld_q || m_axis_tready) begin
            out_load       = 1'b1;
            acc_d          = '0;
            bits_d         = '0;
            win_ctrl.clear = 1'b1;
            st_d           = fskwd_pkg::ST_IDLE;
          end
        end else begin
          acc_d          = acc_q | (8'(bit_q) << bits_q);
          bits_d         = bits_q + 1'b1;
          win_ctrl.clear = 1'b1;
          st_d           = fskwd_pkg::ST_IDLE;
        end
      end
      default: st_d = fskwd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= fskwd_pkg::ST_IDLE;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      acc_q    <= '0;
      bits_q   <= '0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      rd_vld_q <= win_ctrl.rd_en;
      acc_q    <= acc_d;
      bits_q   <= bits_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (out_load) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      byte_q <= acc_q | (8'(bit_q) << 7);
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = byte_q;

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == fskwd_pkg::ST_SCAN) |-> (idx_q < len_eff))
    else $error("scan index past window length");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == fskwd_pkg::ST_LAST) |-> rd_vld_q)
    else $error("last window beat missing");

  a_byte_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (bits_q == '0 && acc_q == '0 && m_axis_tvalid))
    else $error("byte packer not reset after emit");

endmodule
